// ----- design/cor_pkg.sv -----
// ----------------------------------------------------------------------------
// cor_pkg
// Shared constants for the circle octant rasterizer: default widths,
// register map, output beat numbering and point kinds.
// ----------------------------------------------------------------------------
package cor_pkg;

  // default widths of centre coordinates and radius
  localparam int unsigned CoordBitsDef  = 12;
  localparam int unsigned RadiusBitsDef = 11;

  // fixed field widths
  localparam int unsigned ColorBits = 24;
  localparam int unsigned PtBits    = 14;
  localparam int unsigned ApbData   = 32;
  localparam int unsigned ApbAddr   = 4;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegRadius  = 2'd2;
  localparam logic [1:0] RegColor   = 2'd3;

  // output beats within one step: the centre marker, then eight octant points
  localparam int unsigned BeatBits = 4;
  localparam logic [BeatBits-1:0] BeatMarker = 4'd0;
  localparam logic [BeatBits-1:0] BeatFirst  = 4'd1;
  localparam logic [BeatBits-1:0] BeatLast   = 4'd8;

  // point kinds
  localparam logic KindCircle = 1'b0;
  localparam logic KindMarker = 1'b1;

endpackage

// ----- design/cor_regs.sv -----
// ----------------------------------------------------------------------------
// cor_regs
// APB-style configuration registers: centre, radius and colour.
// ----------------------------------------------------------------------------
module cor_regs import cor_pkg::*; #(
  parameter int unsigned CoordBits  = CoordBitsDef,
  parameter int unsigned RadiusBits = RadiusBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ApbAddr-1:0]    paddr,
  input  logic [ApbData-1:0]    pwdata,
  output logic [ApbData-1:0]    prdata,
  output logic                  pready,
  output logic [CoordBits-1:0]  center_x_o,
  output logic [CoordBits-1:0]  center_y_o,
  output logic [RadiusBits-1:0] radius_o,
  output logic [ColorBits-1:0]  color_o
);

  logic [CoordBits-1:0]  center_x_q;
  logic [CoordBits-1:0]  center_y_q;
  logic [RadiusBits-1:0] radius_q;
  logic [ColorBits-1:0]  color_q;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
      color_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegCenterX: center_x_q <= pwdata[CoordBits-1:0];
        RegCenterY: center_y_q <= pwdata[CoordBits-1:0];
        RegRadius:  radius_q   <= pwdata[RadiusBits-1:0];
        RegColor:   color_q    <= pwdata[ColorBits-1:0];
        default:    ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegCenterX: prdata = ApbData'(center_x_q);
      RegCenterY: prdata = ApbData'(center_y_q);
      RegRadius:  prdata = ApbData'(radius_q);
      RegColor:   prdata = ApbData'(color_q);
      default:    prdata = '0;
    endcase
  end

  assign center_x_o = center_x_q;
  assign center_y_o = center_y_q;
  assign radius_o   = radius_q;
  assign color_o    = color_q;

endmodule

// ----- design/cor_isqrt.sv -----
// ----------------------------------------------------------------------------
// cor_isqrt
// Iterative integer square root, one result bit per cycle. Returns the
// floor root and the remainder v - root*root.
// ----------------------------------------------------------------------------
module cor_isqrt import cor_pkg::*; #(
  parameter int unsigned RootBits = RadiusBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*RootBits-1:0] radicand_i,
  output logic                  done_o,
  output logic [RootBits-1:0]   root_o,
  output logic [RootBits+1:0]   rem_o
);

  localparam int unsigned CntBits = $clog2(RootBits + 1);
  localparam int unsigned CurBits = RootBits + 4;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [2*RootBits-1:0] rad_q, rad_d;
  logic [RootBits-1:0]   root_q, root_d;
  logic [RootBits+1:0]   rem_q, rem_d;
  logic [CurBits-1:0]    cur;
  logic [CurBits-1:0]    trial;

  // partial remainder with the next two radicand bits, and the trial value
  assign cur   = {rem_q, rad_q[2*RootBits-1 -: 2]};
  assign trial = CurBits'({root_q, 2'b01});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      // one restoring step
      rad_d = {rad_q[2*RootBits-3:0], 2'b00};
      if (cur >= trial) begin
        rem_d  = (RootBits+2)'(cur - trial);
        root_d = {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_d  = (RootBits+2)'(cur);
        root_d = {root_q[RootBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(RootBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;

endmodule

// ----- design/circle_octant_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_top
// Circle outline rasterizer: one octant point per step, square root by an
// iterative unit, eight mirrored points out per step (after a centre marker on restart).
// ----------------------------------------------------------------------------
// A restart transaction begins a circle at column offset 0 and emits the
// centre marker followed by eight mirrored points; each later transaction
// advances the offset by one and emits eight points. The octant height is
// the rounded integer square root of r*r - x*x. A step whose x is not below
// its height flags circle_done, after which plain advance transactions emit
// nothing. A drawing step passes through the shared multiplier and the
// subtractor, then the bit-serial square root (the dominant loop), then
// emits its 8 or 9 output points. The input is not ready while a step is in
// progress; the last point of a step may still wait in the output register
// while the next transaction is taken.
// ----------------------------------------------------------------------------
module circle_octant_rasterizer_top import cor_pkg::*; #(
  parameter int unsigned CoordBits  = CoordBitsDef,
  parameter int unsigned RadiusBits = RadiusBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ApbAddr-1:0]       paddr,
  input  logic [ApbData-1:0]       pwdata,
  output logic [ApbData-1:0]       prdata,
  output logic                     pready,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     restart_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [PtBits-1:0] point_x_o,
  output logic signed [PtBits-1:0] point_y_o,
  output logic                     point_kind_o,
  output logic [ColorBits-1:0]     point_color_o,
  output logic                     last_of_step_o,
  output logic                     circle_done_o
);

  localparam int unsigned MaxIn  = (CoordBits > RadiusBits) ? CoordBits : RadiusBits;
  localparam int unsigned CalcW  = (MaxIn + 2 > PtBits) ? MaxIn + 2 : PtBits;
  localparam int unsigned SqBits = 2 * RadiusBits;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL_R = 5'b00010,
    S_MUL_X = 5'b00100,
    S_DIFF  = 5'b01000,
    S_SQRT  = 5'b10000
  } state_e;

  logic [CoordBits-1:0]  center_x;
  logic [CoordBits-1:0]  center_y;
  logic [RadiusBits-1:0] radius;
  logic [ColorBits-1:0]  color;

  state_e                state_q, state_d;
  logic                  emit_q, emit_d;
  logic                  active_q, active_d;
  logic                  restart_q, restart_d;
  logic [RadiusBits-1:0] offset_q, offset_d;
  logic [BeatBits-1:0]   beat_q, beat_d;
  logic [SqBits-1:0]     prod_q;
  logic [SqBits-1:0]     r2_q;
  logic [RadiusBits-1:0] y_q;
  logic [RadiusBits-1:0] mul_op;
  logic [SqBits-1:0]     diff;
  logic                  sqrt_start;
  logic                  sqrt_done;
  logic [RadiusBits-1:0] sqrt_root;
  logic [RadiusBits+1:0] sqrt_rem;
  logic                  in_acc;
  logic                  load;
  logic                  step_done;

  logic                  out_valid_q, out_valid_d;
  logic [PtBits-1:0]     point_x_q, point_y_q;
  logic                  kind_q;
  logic [ColorBits-1:0]  color_q;
  logic                  last_q;
  logic                  done_q;

  // selected point offsets for the current beat
  logic [RadiusBits-1:0] h_mag, v_mag;
  logic                  h_neg, v_neg;
  logic [CalcW-1:0]      px, py;

  cor_regs #(
    .CoordBits  (CoordBits),
    .RadiusBits (RadiusBits)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .center_x_o (center_x),
    .center_y_o (center_y),
    .radius_o   (radius),
    .color_o    (color)
  );

  cor_isqrt #(
    .RootBits (RadiusBits)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (diff),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root),
    .rem_o      (sqrt_rem)
  );

  // shared squaring multiplier: radius first, then column offset
  assign mul_op = (state_q == S_MUL_R) ? radius : offset_q;

  always_ff @(posedge clk_i) begin
    prod_q <= SqBits'(mul_op) * SqBits'(mul_op);
    if (state_q == S_MUL_X) begin
      r2_q <= prod_q;
    end
    // round to nearest: remainder above the floor root bumps it
    if (sqrt_done) begin
      y_q <= (sqrt_rem > (RadiusBits+2)'(sqrt_root)) ? sqrt_root + 1'b1 : sqrt_root;
    end
  end

  // radicand clamped at zero
  assign diff       = (r2_q > prod_q) ? r2_q - prod_q : '0;
  assign sqrt_start = (state_q == S_DIFF);

  assign in_ready_o = (state_q == S_IDLE) && !emit_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load       = emit_q && (!out_valid_q || out_ready_i);
  assign step_done  = (offset_q >= y_q);

  // step sequencer
  always_comb begin
    state_d   = state_q;
    emit_d    = emit_q;
    active_d  = active_q;
    restart_d = restart_q;
    offset_d  = offset_q;
    beat_d    = beat_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (restart_i || active_q)) begin
          restart_d = restart_i;
          if (restart_i) begin
            offset_d = '0;
            active_d = 1'b1;
          end
          state_d = S_MUL_R;
        end
      end
      S_MUL_R: state_d = S_MUL_X;
      S_MUL_X: state_d = S_DIFF;
      S_DIFF:  state_d = S_SQRT;
      S_SQRT: begin
        if (sqrt_done) begin
          emit_d  = 1'b1;
          beat_d  = restart_q ? BeatMarker : BeatFirst;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // output beats run from the idle state, before the next transaction
    if (load) begin
      beat_d = beat_q + 1'b1;
      if (beat_q == BeatLast) begin
        emit_d   = 1'b0;
        offset_d = offset_q + 1'b1;
        if (step_done) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      emit_q    <= 1'b0;
      active_q  <= 1'b0;
      restart_q <= 1'b0;
      offset_q  <= '0;
      beat_q    <= '0;
    end else begin
      state_q   <= state_d;
      emit_q    <= emit_d;
      active_q  <= active_d;
      restart_q <= restart_d;
      offset_q  <= offset_d;
      beat_q    <= beat_d;
    end
  end

  // mirror selection for the eight octants
  always_comb begin
    h_mag = '0;
    v_mag = '0;
    h_neg = 1'b0;
    v_neg = 1'b0;
    case (beat_q)
      4'd1: begin h_mag = offset_q; h_neg = 1'b0; v_mag = y_q;      v_neg = 1'b1; end
      4'd2: begin h_mag = offset_q; h_neg = 1'b1; v_mag = y_q;      v_neg = 1'b1; end
      4'd3: begin h_mag = y_q;      h_neg = 1'b1; v_mag = offset_q; v_neg = 1'b1; end
      4'd4: begin h_mag = y_q;      h_neg = 1'b1; v_mag = offset_q; v_neg = 1'b0; end
      4'd5: begin h_mag = offset_q; h_neg = 1'b1; v_mag = y_q;      v_neg = 1'b0; end
      4'd6: begin h_mag = offset_q; h_neg = 1'b0; v_mag = y_q;      v_neg = 1'b0; end
      4'd7: begin h_mag = y_q;      h_neg = 1'b0; v_mag = offset_q; v_neg = 1'b0; end
      4'd8: begin h_mag = y_q;      h_neg = 1'b0; v_mag = offset_q; v_neg = 1'b1; end
      default: ;
    endcase
  end

  assign px = h_neg ? CalcW'(center_x) - CalcW'(h_mag) : CalcW'(center_x) + CalcW'(h_mag);
  assign py = v_neg ? CalcW'(center_y) - CalcW'(v_mag) : CalcW'(center_y) + CalcW'(v_mag);

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      point_x_q <= px[PtBits-1:0];
      point_y_q <= py[PtBits-1:0];
      kind_q    <= (beat_q == BeatMarker) ? KindMarker : KindCircle;
      color_q   <= color;
      last_q    <= (beat_q == BeatLast);
      done_q    <= step_done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = point_x_q;
  assign point_y_o      = point_y_q;
  assign point_kind_o   = kind_q;
  assign point_color_o  = color_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule
